@@ design/uvs_pkg.sv @@
package uvs_pkg;

	localparam int CNT_W      = 9;
	localparam int RAD_W      = 16;
	localparam int POS_W      = 17;
	localparam int NRM_W      = 16;
	localparam int K_W        = 17;
	localparam int PH_W       = 32;
	localparam int AW         = 33;
	localparam int CW         = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int ARC_LEN    = 24;

	localparam int DEF_MAX_SECTORS   = 256;
	localparam int DEF_MAX_STACKS    = 256;
	localparam int DEF_CORDIC_STAGES = 16;

	localparam int MIN_SECTORS = 3;
	localparam int MIN_STACKS  = 2;
	localparam int RST_SECTORS = 36;
	localparam int RST_STACKS  = 18;
	localparam logic [RAD_W-1:0] RST_RADIUS = 16'd256;

	localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STACKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd2;

	localparam logic [PH_W-1:0] PH_QUARTER = 32'h4000_0000;
	localparam logic signed [AW-1:0] GAIN = 33'sd652032874;
	localparam logic signed [AW-1:0] QTR  = 33'sd1073741824;
	localparam logic signed [AW-1:0] HALF = 33'sd2147483648;

	localparam logic signed [AW-1:0] ARC [0:ARC_LEN-1] = '{
		33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4,
		33'sh028B0D43, 33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55,
		33'sh0028BE53, 33'sh00145F2F, 33'sh000A2F98, 33'sh000517CC,
		33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA, 33'sh0000517D,
		33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
		33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051
	};

	typedef struct packed {
		logic valid;
		logic [CNT_W-1:0] i;
		logic [CNT_W-1:0] j;
		logic [CNT_W-1:0] sc;
		logic [CNT_W-1:0] st;
	} uvs_ctl_t;

	typedef struct packed {
		uvs_ctl_t ctl;
		logic [CNT_W-1:0] rb;
		logic [CNT_W-1:0] ra;
		logic [PH_W-1:0] qb;
		logic [PH_W-1:0] qa;
	} uvs_div_t;

	typedef struct packed {
		logic signed [AW-1:0] x;
		logic signed [AW-1:0] y;
		logic signed [AW-1:0] z;
		logic flip;
	} uvs_lane_t;

	typedef struct packed {
		uvs_ctl_t ctl;
		uvs_lane_t la;
		uvs_lane_t lb;
	} uvs_cor_t;

	typedef struct packed {
		logic signed [POS_W-1:0] px;
		logic signed [POS_W-1:0] py;
		logic signed [POS_W-1:0] pz;
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic [K_W-1:0] k1;
		logic [K_W-1:0] k2;
		logic has1;
		logic has2;
	} uvs_vtx_t;

	function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v, input int lo,
		input int hi);
		int t;
		t = int'(v);
		if (t < lo)
			t = lo;
		if (t > hi)
			t = hi;
		return CNT_W'(t);
	endfunction

	function automatic uvs_lane_t fold(input logic [PH_W-1:0] ph);
		uvs_lane_t l;
		logic signed [AW-1:0] z;
		z = AW'($signed(ph));
		l.x = GAIN;
		l.y = '0;
		l.flip = 1'b0;
		if (z > QTR) begin
			z = z - HALF;
			l.flip = 1'b1;
		end else if (z < -QTR) begin
			z = z + HALF;
			l.flip = 1'b1;
		end
		l.z = z;
		return l;
	endfunction

	function automatic logic signed [CW-1:0] trig(input logic signed [AW-1:0] v,
		input logic flip);
		logic signed [AW:0] w;
		w = flip ? -((AW+1)'(v)) : (AW+1)'(v);
		w = w + (AW+1)'(34'sd8192);
		return w[CW+13:14];
	endfunction

	function automatic logic signed [55:0] rnd(input logic signed [55:0] v, input int s);
		return (v + (56'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_sym(input logic signed [55:0] v,
		input int lim);
		logic signed [55:0] l;
		l = 56'(lim);
		if (v > l)
			return POS_W'(l);
		if (v < -l)
			return POS_W'(-l);
		return v[POS_W-1:0];
	endfunction

endpackage

@@ design/uvs_if.sv @@
interface uvs_pt_if;
	import uvs_pkg::*;
	logic valid;
	logic ready;
	logic [CNT_W-1:0] stack_index;
	logic [CNT_W-1:0] sector_index;
	modport source(output valid, stack_index, sector_index, input ready);
	modport sink(input valid, stack_index, sector_index, output ready);
endinterface

interface uvs_res_if;
	import uvs_pkg::*;
	logic valid;
	logic ready;
	logic kind;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic signed [NRM_W-1:0] norm_x;
	logic signed [NRM_W-1:0] norm_y;
	logic signed [NRM_W-1:0] norm_z;
	logic [K_W-1:0] corner_a;
	logic [K_W-1:0] corner_b;
	logic [K_W-1:0] corner_c;
	logic last_of_run;
	modport source(output valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		corner_a, corner_b, corner_c, last_of_run, input ready);
	modport sink(input valid, kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		corner_a, corner_b, corner_c, last_of_run, output ready);
endinterface

interface uvs_cfg_if;
	import uvs_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ design/uvs_div_cell.sv @@
module uvs_div_cell #(
	parameter int POS = 31
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  uvs_pkg::uvs_div_t d,
	output uvs_pkg::uvs_div_t q
);
	import uvs_pkg::*;

	logic [33:0] hb_w, ha_w;
	logic nb, na;
	logic [CNT_W:0] tb, ta, db, da;
	logic v_q;
	uvs_div_t p_q, nxt;

	always_comb begin
		hb_w = 34'(d.ctl.sc);
		ha_w = 34'(d.ctl.st);
		nb = hb_w[POS+1];
		na = (POS == 31) ? d.ctl.i[0] : ha_w[POS+1];
		tb = {d.rb, nb};
		ta = {d.ra, na};
		db = {1'b0, d.ctl.sc};
		da = {1'b0, d.ctl.st};
		nxt = d;
		nxt.qb = {d.qb[PH_W-2:0], tb >= db};
		nxt.qa = {d.qa[PH_W-2:0], ta >= da};
		nxt.rb = (tb >= db) ? CNT_W'(tb - db) : CNT_W'(tb);
		nxt.ra = (ta >= da) ? CNT_W'(ta - da) : CNT_W'(ta);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= d.ctl.valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			p_q <= nxt;
	end

	always_comb begin
		q = p_q;
		q.ctl.valid = v_q;
	end

endmodule

@@ design/uvs_cordic_cell.sv @@
module uvs_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  uvs_pkg::uvs_cor_t d,
	output uvs_pkg::uvs_cor_t q
);
	import uvs_pkg::*;

	function automatic uvs_lane_t rot(input uvs_lane_t l);
		logic signed [AW-1:0] x, y, z, xs, ys;
		uvs_lane_t r;
		x = l.x;
		y = l.y;
		z = l.z;
		xs = x >>> IDX;
		ys = y >>> IDX;
		r = l;
		if (z >= 0) begin
			r.x = x - ys;
			r.y = y + xs;
			r.z = z - ARC[IDX];
		end else begin
			r.x = x + ys;
			r.y = y - xs;
			r.z = z + ARC[IDX];
		end
		return r;
	endfunction

	logic v_q;
	uvs_cor_t p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (en)
			v_q <= d.ctl.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q.ctl <= d.ctl;
			p_q.la <= rot(d.la);
			p_q.lb <= rot(d.lb);
		end
	end

	always_comb begin
		q = p_q;
		q.ctl.valid = v_q;
	end

endmodule

@@ design/uvs_out_buf.sv @@
module uvs_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  uvs_pkg::uvs_vtx_t vin,
	input  logic              vin_valid,
	output logic              take,
	uvs_res_if.source         res
);
	import uvs_pkg::*;

	localparam logic [1:0] PH_VTX = 2'd0;
	localparam logic [1:0] PH_T1  = 2'd1;
	localparam logic [1:0] PH_T2  = 2'd2;

	logic [1:0] phase_q;
	logic bv_q;
	uvs_vtx_t data_q;
	logic last;

	always_comb begin
		case (phase_q)
			PH_VTX:  last = !data_q.has1 && !data_q.has2;
			PH_T1:   last = !data_q.has2;
			default: last = 1'b1;
		endcase
	end

	assign take = !bv_q || (res.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q <= 1'b0;
			phase_q <= PH_VTX;
		end else if (take) begin
			bv_q <= vin_valid;
			phase_q <= PH_VTX;
		end else if (res.ready) begin
			phase_q <= (phase_q == PH_VTX && data_q.has1) ? PH_T1 : PH_T2;
		end
	end

	always_ff @(posedge clk) begin
		if (take && vin_valid)
			data_q <= vin;
	end

	always_comb begin
		res.valid = bv_q;
		res.kind = (phase_q != PH_VTX);
		res.last_of_run = last;
		res.pos_x = '0;
		res.pos_y = '0;
		res.pos_z = '0;
		res.norm_x = '0;
		res.norm_y = '0;
		res.norm_z = '0;
		res.corner_a = '0;
		res.corner_b = '0;
		res.corner_c = '0;
		case (phase_q)
			PH_VTX: begin
				res.pos_x = data_q.px;
				res.pos_y = data_q.py;
				res.pos_z = data_q.pz;
				res.norm_x = data_q.nx;
				res.norm_y = data_q.ny;
				res.norm_z = data_q.nz;
			end
			PH_T1: begin
				res.corner_a = data_q.k1;
				res.corner_b = data_q.k2;
				res.corner_c = data_q.k1 + K_W'(1);
			end
			PH_T2: begin
				res.corner_a = data_q.k1 + K_W'(1);
				res.corner_b = data_q.k2;
				res.corner_c = data_q.k2 + K_W'(1);
			end
			default: begin
			end
		endcase
	end

	a_t2_has: assert property (@(posedge clk) disable iff (!arst_n)
		(bv_q && phase_q == PH_T2) |-> data_q.has2)
		else $error("second triangle sent without being due");
	a_t1_has: assert property (@(posedge clk) disable iff (!arst_n)
		(bv_q && phase_q == PH_T1) |-> data_q.has1)
		else $error("first triangle sent without being due");
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.last_of_run) |=> (res.valid && phase_q != PH_VTX))
		else $error("run broken before its last result");

endmodule

@@ design/uv_sphere_tessellator.sv @@
// UV sphere tessellator: each grid point item (stack_index, sector_index) yields a vertex
// result (Q8.8 position, Q1.14 normal) followed by zero to two triangle results, the last
// marked by last_of_run. Angles come from a row of 32 long-division cells (one quotient
// bit per cell) followed by a row of CORDIC_STAGES rotation cells and three output
// stages (rounding, then two multiply stages), and then a result buffer. A new item
// enters every cycle while the result port keeps up; the result port sends one result per
// cycle while res.ready is high, so an item with triangles holds back later items until its
// last result is taken. Configuration writes are taken every cycle and should be made while
// idle.
module uv_sphere_tessellator #(
	parameter int MAX_SECTORS   = uvs_pkg::DEF_MAX_SECTORS,
	parameter int MAX_STACKS    = uvs_pkg::DEF_MAX_STACKS,
	parameter int CORDIC_STAGES = uvs_pkg::DEF_CORDIC_STAGES
) (
	input logic       clk,
	input logic       arst_n,
	uvs_cfg_if.sink   cfg,
	uvs_pt_if.sink    pt,
	uvs_res_if.source res
);
	import uvs_pkg::*;

	logic [CNT_W-1:0] sc_q, st_q;
	logic [RAD_W-1:0] rad_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= clamp_cnt(CNT_W'(RST_SECTORS), MIN_SECTORS, MAX_SECTORS);
			st_q <= clamp_cnt(CNT_W'(RST_STACKS), MIN_STACKS, MAX_STACKS);
			rad_q <= RST_RADIUS;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SECTORS: sc_q <= clamp_cnt(cfg.data[CNT_W-1:0], MIN_SECTORS, MAX_SECTORS);
				REG_STACKS:  st_q <= clamp_cnt(cfg.data[CNT_W-1:0], MIN_STACKS, MAX_STACKS);
				REG_RADIUS: begin
					if (cfg.data != '0)
						rad_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	logic adv, take;
	logic [CNT_W-1:0] i_in, j_in;
	uvs_div_t dv [0:32];
	uvs_cor_t cor [0:CORDIC_STAGES];

	assign pt.ready = adv;

	always_comb begin
		i_in = (pt.stack_index > st_q) ? st_q : pt.stack_index;
		j_in = (pt.sector_index > sc_q) ? sc_q : pt.sector_index;
		dv[0].ctl.valid = pt.valid;
		dv[0].ctl.i = i_in;
		dv[0].ctl.j = j_in;
		dv[0].ctl.sc = sc_q;
		dv[0].ctl.st = st_q;
		dv[0].rb = (j_in >= sc_q) ? j_in - sc_q : j_in;
		dv[0].ra = i_in >> 1;
		dv[0].qb = '0;
		dv[0].qa = '0;
	end

	for (genvar k = 0; k < 32; k++) begin : g_div
		uvs_div_cell #(.POS(31 - k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .d(dv[k]), .q(dv[k+1])
		);
	end

	always_comb begin
		cor[0].ctl = dv[32].ctl;
		cor[0].la = fold(PH_QUARTER - dv[32].qa);
		cor[0].lb = fold(dv[32].qb);
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
		uvs_cordic_cell #(.IDX(k)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .d(cor[k]), .q(cor[k+1])
		);
	end

	logic v_s1, v_s2, v_s3;
	uvs_ctl_t ctl_s1;
	logic signed [CW-1:0] ca_s1, sa_s1, cb_s1, sb_s1;
	logic signed [CW-1:0] sa_s2, cb_s2, sb_s2, sa_s3;
	logic signed [35:0] xy_s2, pz_s2, pz_s3;
	logic signed [37:0] nx_s2, ny_s2, nx_s3, ny_s3;
	logic signed [54:0] px_s3, py_s3;
	logic [19:0] k1_s2;
	logic [CNT_W-1:0] sc_s2;
	logic [K_W-1:0] k1_s3, k2_s3;
	logic has1_s2, has2_s2, has1_s3, has2_s3;
	logic cell_in;
	logic signed [RAD_W:0] r_s;
	uvs_vtx_t vtx;

	assign adv = !v_s3 || take;
	assign r_s = $signed({1'b0, rad_q});
	assign cell_in = (ctl_s1.i < ctl_s1.st) && (ctl_s1.j < ctl_s1.sc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cor[CORDIC_STAGES].ctl.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= cor[CORDIC_STAGES].ctl;
			ca_s1 <= trig(cor[CORDIC_STAGES].la.x, cor[CORDIC_STAGES].la.flip);
			sa_s1 <= trig(cor[CORDIC_STAGES].la.y, cor[CORDIC_STAGES].la.flip);
			cb_s1 <= trig(cor[CORDIC_STAGES].lb.x, cor[CORDIC_STAGES].lb.flip);
			sb_s1 <= trig(cor[CORDIC_STAGES].lb.y, cor[CORDIC_STAGES].lb.flip);

			xy_s2 <= r_s * ca_s1;
			pz_s2 <= r_s * sa_s1;
			nx_s2 <= ca_s1 * cb_s1;
			ny_s2 <= ca_s1 * sb_s1;
			sa_s2 <= sa_s1;
			cb_s2 <= cb_s1;
			sb_s2 <= sb_s1;
			k1_s2 <= 20'(ctl_s1.i) * (20'(ctl_s1.sc) + 20'd1) + 20'(ctl_s1.j);
			sc_s2 <= ctl_s1.sc;
			has1_s2 <= cell_in && (ctl_s1.i != '0);
			has2_s2 <= cell_in && (ctl_s1.i != ctl_s1.st - CNT_W'(1));

			px_s3 <= xy_s2 * cb_s2;
			py_s3 <= xy_s2 * sb_s2;
			pz_s3 <= pz_s2;
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			sa_s3 <= sa_s2;
			k1_s3 <= k1_s2[K_W-1:0];
			k2_s3 <= k1_s2[K_W-1:0] + K_W'(sc_s2) + K_W'(1);
			has1_s3 <= has1_s2;
			has2_s3 <= has2_s2;
		end
	end

	always_comb begin
		vtx.px = sat_sym(rnd(56'(px_s3), 32), 65535);
		vtx.py = sat_sym(rnd(56'(py_s3), 32), 65535);
		vtx.pz = sat_sym(rnd(56'(pz_s3), 16), 65535);
		vtx.nx = NRM_W'(sat_sym(rnd(56'(nx_s3), 18), 16384));
		vtx.ny = NRM_W'(sat_sym(rnd(56'(ny_s3), 18), 16384));
		vtx.nz = NRM_W'(sat_sym(rnd(56'(sa_s3), 2), 16384));
		vtx.k1 = k1_s3;
		vtx.k2 = k2_s3;
		vtx.has1 = has1_s3;
		vtx.has2 = has2_s3;
	end

	uvs_out_buf u_out (
		.clk(clk), .arst_n(arst_n), .vin(vtx), .vin_valid(v_s3), .take(take), .res(res)
	);

	a_rad_nz: assert property (@(posedge clk) disable iff (!arst_n) rad_q != '0)
		else $error("radius register holds zero");
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !adv) |=> v_s3)
		else $error("tail item lost during stall");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && pt.ready) |=> dv[1].ctl.valid)
		else $error("accepted item missing from first cell");

endmodule
